/* rtl/core/kfi_pkg.sv */
// Package: shared types and constants for the keyframe interpolator.
`default_nettype none
package kfi_pkg;
    localparam int MAX_KEYS   = 16;
    localparam int FRAC_BITS  = 16;
    localparam int CNT_W      = $clog2(MAX_KEYS + 1);
    localparam int IDX_W      = $clog2(MAX_KEYS);
    // divider numerator, quotient and lerp product widths
    localparam int NUM_W      = 32 + FRAC_BITS;
    localparam int QUO_W      = FRAC_BITS + 1;
    localparam int PROD_W     = QUO_W + 33;
    localparam int DIV_CNT_W  = $clog2(NUM_W + 1);

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_SET    = 2'd2,
        FUNC_ADD    = 2'd3
    } t_func;

    typedef struct packed {
        logic signed [31:0] t;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] r;
    } t_key;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] time_value;
        logic signed [31:0] key_x;
        logic signed [31:0] key_y;
        logic signed [31:0] key_rotation;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_rotation;
        logic signed [31:0] total_time;
        logic [4:0]         key_count;
        logic               rejected;
    } t_out;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic               clear;
        logic               insert;
        logic               shift;
        logic signed [31:0] ins_time;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_DIV,
        ST_MUL,
        ST_SUM,
        ST_OUT
    } t_state;
endpackage
`default_nettype wire

/* rtl/core/kfi_if.sv */
// Interfaces: valid/ready channels for input and result items.
`default_nettype none
interface kfi_in_if;
    logic         valid;
    logic         ready;
    kfi_pkg::t_in data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface kfi_out_if;
    logic          valid;
    logic          ready;
    kfi_pkg::t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/kfi_cell.sv */
// Cell: one keyframe slot of the sorted shift chain.
`default_nettype none
module kfi_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire kfi_pkg::t_cell_ctl i_ctl,
    input  wire kfi_pkg::t_key     i_new,
    input  wire kfi_pkg::t_key     i_prev,
    input  wire logic              i_prev_vld,
    input  wire logic              i_prev_gt,
    output      kfi_pkg::t_key     o_key,
    output      logic              o_vld,
    output      logic              o_gt
);
    import kfi_pkg::*;
    t_key r_key;
    logic r_vld;

    // this entry lies strictly after the new time
    assign o_gt  = r_vld && (r_key.t > i_ctl.ins_time);
    assign o_key = r_key;
    assign o_vld = r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_vld <= 1'b0;
        end else if (i_ctl.insert) begin
            if (o_gt) begin
                r_vld <= 1'b1;
                r_key <= i_prev_gt ? i_prev : i_new;
            end else if (!r_vld && (i_prev_vld || i_prev_gt)) begin
                // first empty slot takes the new key or the shifted one
                r_vld <= 1'b1;
                r_key <= i_prev_gt ? i_prev : i_new;
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/core/kfi_div.sv */
// Divider: restoring unsigned division, one quotient bit per cycle.
`default_nettype none
module kfi_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [kfi_pkg::NUM_W-1:0] i_num,
    input  wire logic [32:0]               i_den,
    output      logic [kfi_pkg::QUO_W-1:0] o_quo,
    output      logic                      o_done
);
    import kfi_pkg::*;
    logic [NUM_W-1:0]     r_num;
    logic [32:0]          r_rem;
    logic [32:0]          r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic [33:0]          w_try;
    logic [33:0]          w_sh;

    assign w_sh  = {r_rem, r_num[NUM_W-1]};
    assign w_try = w_sh - {1'b0, r_den};
    assign o_quo = r_num[QUO_W-1:0];
    assign o_done = r_busy && (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(NUM_W);
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
        end else if (r_busy && r_cnt != '0) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
            if (!w_try[33]) begin
                r_rem <= w_try[32:0];
                r_num <= {r_num[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= w_sh[32:0];
                r_num <= {r_num[NUM_W-2:0], 1'b0};
            end
        end else begin
            r_busy <= 1'b0;
        end
    end
endmodule
`default_nettype wire

/* rtl/core/keyframe_interpolator.sv */
// Top level: keyframe table chain, segment scan, divider and lerp sequencer.
// Usage:
//   i_in carries one command item (func, time_value, key fields). The block
//   takes one item at a time; i_in.ready is high only when no item is at work.
//   Per item: table/time update, segment scan, then on an interior segment
//   serial division (one quotient bit per cycle) and multiply and sum, then
//   the load of the result register. Clamped frames go from the scan
//   straight to the load step.
//   o_out presents the result from a register; it holds while o_out.ready is
//   low. The next item is taken and worked meanwhile, and its result waits in
//   the load step until the register frees.
//   Reset empties the table and zeros the current time; no clearing pass.
//   Insert into a full table leaves the table as is and flags rejected.
`default_nettype none
module keyframe_interpolator (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    kfi_in_if.sink    i_in,
    kfi_out_if.source o_out
);
    import kfi_pkg::*;

    t_state r_state, n_state;
    t_in    r_cmd;
    logic signed [31:0] r_now;
    logic [CNT_W-1:0]   r_cnt;
    logic [IDX_W-1:0]   r_seg;
    logic [CNT_W-1:0]   r_j;
    logic               r_rej;
    logic               r_ovld;
    t_out               r_out;
    t_key               r_a, r_b;
    logic [QUO_W-1:0]   r_f;
    logic signed [PROD_W-1:0] r_px, r_py, r_pr;

    t_cell_ctl          w_ctl;
    t_key               w_new;
    t_key               w_key [MAX_KEYS];
    logic               w_vld [MAX_KEYS];
    logic               w_gt  [MAX_KEYS];
    logic               w_div_start;
    logic [QUO_W-1:0]   w_quo;
    logic               w_div_done;
    logic signed [32:0] w_sum;
    t_key               w_kj, w_ki;
    logic [32:0]        w_numd;
    logic [32:0]        w_dend;
    logic               w_load;

    assign w_new = '{t: r_cmd.time_value, x: r_cmd.key_x, y: r_cmd.key_y,
                     r: r_cmd.key_rotation};

    always_comb begin
        w_ctl.clear    = (r_state == ST_UPDATE) && (r_cmd.func == FUNC_CLEAR);
        w_ctl.insert   = (r_state == ST_UPDATE) && (r_cmd.func == FUNC_INSERT)
                         && (r_cnt != CNT_W'(MAX_KEYS));
        w_ctl.shift    = w_ctl.insert;
        w_ctl.ins_time = r_cmd.time_value;
    end

    for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
        kfi_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_new      (w_new),
            .i_prev     ((g == 0) ? w_new : w_key[(g == 0) ? 0 : g - 1]),
            .i_prev_vld ((g == 0) ? 1'b1 : w_vld[(g == 0) ? 0 : g - 1]),
            .i_prev_gt  ((g == 0) ? 1'b0 : w_gt[(g == 0) ? 0 : g - 1]),
            .o_key      (w_key[g]),
            .o_vld      (w_vld[g]),
            .o_gt       (w_gt[g])
        );
    end

    assign w_sum = 33'(r_now) + 33'(r_cmd.time_value);
    assign w_kj  = w_key[r_j[IDX_W-1:0]];
    assign w_ki  = w_key[IDX_W'(r_j - CNT_W'(1))];

    // segment offset and length, taken straight from the chain at divider start
    assign w_numd = {r_now[31], r_now} - {w_ki.t[31], w_ki.t};
    assign w_dend = {w_kj.t[31], w_kj.t} - {w_ki.t[31], w_ki.t};
    assign w_div_start = (r_state == ST_SCAN) && (n_state == ST_DIV);

    kfi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   ({w_numd[31:0], {FRAC_BITS{1'b0}}}),
        .i_den   (w_dend),
        .o_quo   (w_quo),
        .o_done  (w_div_done)
    );

    function automatic logic signed [PROD_W-1:0] mulf(input logic [QUO_W-1:0] f,
                                                      input logic signed [31:0] a,
                                                      input logic signed [31:0] b);
        logic signed [32:0]       d;
        logic signed [PROD_W-1:0] p;
        d = 33'(b) - 33'(a);
        p = $signed({1'b0, f}) * d;
        return p;
    endfunction

    function automatic logic signed [31:0] fin(input logic signed [31:0] a,
                                               input logic signed [PROD_W-1:0] p);
        return 32'(a + 32'(p >>> FRAC_BITS));
    endfunction

    // load the result register once it is free or being taken
    assign w_load = (r_state == ST_OUT) && (!r_ovld || o_out.ready);

    assign i_in.ready = (r_state == ST_IDLE);
    assign o_out.valid = r_ovld;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_in.valid && i_in.ready) n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_SCAN;
            ST_SCAN: begin
                if (r_j >= r_cnt || (r_j < r_cnt && w_kj.t > r_now)) begin
                    if (r_j == '0 || r_j >= r_cnt) n_state = ST_OUT;
                    else n_state = ST_DIV;
                end
            end
            ST_DIV:    if (w_div_done) n_state = ST_MUL;
            ST_MUL:    n_state = ST_SUM;
            ST_SUM:    n_state = ST_OUT;
            ST_OUT:    if (w_load) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now  <= '0;
            r_cnt  <= '0;
            r_seg  <= '0;
            r_ovld <= 1'b0;
        end else begin
            if (w_load) r_ovld <= 1'b1;
            else if (o_out.valid && o_out.ready) r_ovld <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_in.valid && i_in.ready) r_cmd <= i_in.data;
                end
                ST_UPDATE: begin
                    r_j   <= '0;
                    r_rej <= (r_cmd.func == FUNC_INSERT) && (r_cnt == CNT_W'(MAX_KEYS));
                    case (r_cmd.func)
                        FUNC_CLEAR: begin
                            r_cnt <= '0;
                            r_now <= '0;
                            r_seg <= '0;
                        end
                        FUNC_INSERT: begin
                            if (r_cnt != CNT_W'(MAX_KEYS)) r_cnt <= r_cnt + CNT_W'(1);
                        end
                        FUNC_SET: r_now <= r_cmd.time_value;
                        default: begin
                            if (w_sum[32] != w_sum[31])
                                r_now <= w_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                            else
                                r_now <= w_sum[31:0];
                        end
                    endcase
                end
                ST_SCAN: begin
                    if (r_j < r_cnt && !(w_kj.t > r_now)) begin
                        r_j <= r_j + CNT_W'(1);
                    end else if (r_cnt == '0) begin
                        r_a <= '0;
                    end else if (r_j == '0) begin
                        r_a <= w_key[0];
                        r_seg <= '0;
                    end else if (r_j >= r_cnt) begin
                        r_a <= w_ki;
                        r_seg <= (r_cnt >= CNT_W'(2)) ? IDX_W'(r_cnt - CNT_W'(2)) : '0;
                    end else begin
                        r_a <= w_ki;
                        r_b <= w_kj;
                        r_seg <= IDX_W'(r_j - CNT_W'(1));
                    end
                end
                ST_DIV: if (w_div_done) r_f <= w_quo;
                ST_MUL: begin
                    r_px <= mulf(r_f, r_a.x, r_b.x);
                    r_py <= mulf(r_f, r_a.y, r_b.y);
                    r_pr <= mulf(r_f, r_a.r, r_b.r);
                end
                ST_SUM: begin
                    r_a.x <= fin(r_a.x, r_px);
                    r_a.y <= fin(r_a.y, r_py);
                    r_a.r <= fin(r_a.r, r_pr);
                end
                ST_OUT: begin
                    if (w_load) begin
                        r_out.out_x <= r_a.x;
                        r_out.out_y <= r_a.y;
                        r_out.out_rotation <= r_a.r;
                        r_out.total_time <= (r_cnt == '0) ? '0
                                            : w_key[IDX_W'(r_cnt - CNT_W'(1))].t;
                        r_out.key_count <= 5'(r_cnt);
                        r_out.rejected <= r_rej;
                    end
                end
                default: ;
            endcase
        end
    end

    logic w_unused;
    assign w_unused = ^{r_seg, w_ctl.shift};

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.data))
        else $error("result changed while stalled");
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_KEYS)) else $error("count overflow");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> !i_in.ready) else $error("ready while busy");
endmodule
`default_nettype wire

/* sim/keyframe_interpolator_tb.sv */
// Testbench: random and directed keyframe commands checked against an internal predictor.
`timescale 1ns / 1ps
module keyframe_interpolator_tb;
    import kfi_pkg::*;

    localparam int LIMIT_CYCLES = 600000;

    logic i_clk;
    logic i_rst_n;

    kfi_in_if  in_ch ();
    kfi_out_if out_ch ();

    keyframe_interpolator u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    // Predictor state
    logic signed [31:0] key_t [MAX_KEYS];
    logic signed [31:0] key_x [MAX_KEYS];
    logic signed [31:0] key_y [MAX_KEYS];
    logic signed [31:0] key_r [MAX_KEYS];
    int                 key_cnt;
    logic signed [31:0] anim_now;

    t_in  pending_cmds[$];
    t_out expected_frames[$];
    int   mismatches;
    int   cycle_count;
    bit   stim_done;
    bit   hold_sender;
    bit   long_stall;
    bit   stall_done;
    bit   drain_done;
    int   stall_left;
    int   gap_left;
    int   burst_left;

    function automatic logic signed [31:0] lerp_value(logic signed [31:0] a,
                                                      logic signed [31:0] b,
                                                      longint frac);
        longint prod;
        longint shifted;
        prod = frac * (longint'(b) - longint'(a));
        if (prod >= 0) shifted = prod >>> FRAC_BITS;
        else shifted = -(((-prod) + ((longint'(1) << FRAC_BITS) - 1)) >>> FRAC_BITS);
        return 32'(longint'(a) + shifted);
    endfunction

    function automatic t_out apply_command(t_in cmd);
        t_out res;
        int pos, j, i;
        longint sum, num, den, frac;
        res = '0;
        case (t_func'(cmd.func))
            FUNC_CLEAR: begin
                key_cnt = 0;
                anim_now = 0;
            end
            FUNC_INSERT: begin
                if (key_cnt >= MAX_KEYS) begin
                    res.rejected = 1'b1;
                end else begin
                    for (pos = 0; pos < key_cnt; pos++)
                        if (key_t[pos] > cmd.time_value) break;
                    for (int k = key_cnt; k > pos; k--) begin
                        key_t[k] = key_t[k-1];
                        key_x[k] = key_x[k-1];
                        key_y[k] = key_y[k-1];
                        key_r[k] = key_r[k-1];
                    end
                    key_t[pos] = cmd.time_value;
                    key_x[pos] = cmd.key_x;
                    key_y[pos] = cmd.key_y;
                    key_r[pos] = cmd.key_rotation;
                    key_cnt++;
                end
            end
            FUNC_SET: anim_now = cmd.time_value;
            default: begin
                sum = longint'(anim_now) + longint'(cmd.time_value);
                if (sum > 64'sd2147483647) sum = 64'sd2147483647;
                if (sum < -64'sd2147483648) sum = -64'sd2147483648;
                anim_now = 32'(sum);
            end
        endcase
        if (key_cnt > 0) begin
            for (j = 0; j < key_cnt; j++)
                if (key_t[j] > anim_now) break;
            if (j == 0) begin
                res.out_x = key_x[0]; res.out_y = key_y[0]; res.out_rotation = key_r[0];
            end else if (j >= key_cnt) begin
                res.out_x = key_x[key_cnt-1];
                res.out_y = key_y[key_cnt-1];
                res.out_rotation = key_r[key_cnt-1];
            end else begin
                i = j - 1;
                num = longint'(anim_now) - longint'(key_t[i]);
                den = longint'(key_t[j]) - longint'(key_t[i]);
                frac = (den > 0) ? (num * (longint'(1) << FRAC_BITS)) / den : 0;
                res.out_x = lerp_value(key_x[i], key_x[j], frac);
                res.out_y = lerp_value(key_y[i], key_y[j], frac);
                res.out_rotation = lerp_value(key_r[i], key_r[j], frac);
            end
            res.total_time = key_t[key_cnt-1];
        end
        res.key_count = 5'(key_cnt);
        return res;
    endfunction

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return 32'(int'($urandom_range(0, 200)) - 100);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in make_cmd(t_func f, logic signed [31:0] tv);
        t_in c;
        c.func = f;
        c.time_value = tv;
        c.key_x = rand_word();
        c.key_y = rand_word();
        c.key_rotation = rand_word();
        return c;
    endfunction

    // Append an item to the tail of the pending queue
    function automatic void add_cmd(t_in c);
        pending_cmds.insert(pending_cmds.size(), c);
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Driver: bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
            gap_left    <= 0;
            burst_left  <= 0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_ch.valid <= 1'b0;
            end else if (pending_cmds.size() > 0 && !hold_sender) begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= pending_cmds.pop_front();
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 12);
                    if ($urandom_range(0, 2) == 0) gap_left <= $urandom_range(1, 40);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Predict on acceptance
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready)
            expected_frames.insert(expected_frames.size(), apply_command(in_ch.data));
    end

    // Receiver: stall pattern plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left   <= 0;
        end else if (long_stall) begin
            out_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if (cycle_count[10] && $urandom_range(0, 9) == 0) begin
            stall_left   <= $urandom_range(1, 30);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        t_out exp_frame;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_frames.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("Unexpected result item: %p", out_ch.data);
            end else begin
                exp_frame = expected_frames.pop_front();
                if (out_ch.data !== exp_frame) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("Mismatch: expected %p, got %p", exp_frame, out_ch.data);
                end
            end
        end
    end

    // Timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int ntime;
        int nrand;
        logic signed [31:0] base;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        key_cnt = 0;
        anim_now = 0;
        mismatches = 0;
        cycle_count = 0;
        stim_done = 0;
        hold_sender = 0;
        long_stall = 0;
        stall_done = 0;
        drain_done = 0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, single key, equal times, clamping, saturation
        add_cmd(make_cmd(FUNC_SET, 32'sd5));
        add_cmd(make_cmd(FUNC_INSERT, 32'sd100));
        add_cmd(make_cmd(FUNC_INSERT, 32'sd100));
        add_cmd(make_cmd(FUNC_INSERT, 32'sh80000000));
        add_cmd(make_cmd(FUNC_INSERT, 32'sh7FFFFFFF));
        add_cmd(make_cmd(FUNC_SET, 32'sh80000000));
        add_cmd(make_cmd(FUNC_SET, 32'sd100));
        add_cmd(make_cmd(FUNC_ADD, 32'sd12345));
        add_cmd(make_cmd(FUNC_ADD, 32'sh7FFFFFFF));
        add_cmd(make_cmd(FUNC_ADD, 32'sh7FFFFFFF));
        add_cmd(make_cmd(FUNC_SET, 32'sd50));
        add_cmd(make_cmd(FUNC_ADD, 32'sh80000000));
        add_cmd(make_cmd(FUNC_ADD, 32'sh80000000));
        add_cmd(make_cmd(FUNC_SET, 32'sh40000000));
        for (int k = 0; k < 13; k++)
            add_cmd(make_cmd(FUNC_INSERT, $urandom));
        add_cmd(make_cmd(FUNC_CLEAR, $urandom));

        // Random: fill a table with sorted-ish keys, then sweep time
        nrand = 0;
        while (nrand < 1080) begin
            ntime = $urandom_range(1, MAX_KEYS + 2);
            base = (nrand % 5 == 0) ? $urandom : 32'(int'($urandom_range(0, 4000)) - 2000);
            add_cmd(make_cmd(FUNC_CLEAR, $urandom));
            for (int k = 0; k < ntime; k++)
                add_cmd(make_cmd(FUNC_INSERT,
                    (nrand % 7 == 0) ? rand_word() : base + $urandom_range(0, 3000)));
            nrand += ntime + 1;
            for (int k = 0; k < 12; k++) begin
                if ($urandom_range(0, 1) == 0)
                    add_cmd(make_cmd(FUNC_SET,
                        ($urandom_range(0, 5) == 0) ? rand_word() : base + $urandom_range(0, 3200)));
                else
                    add_cmd(make_cmd(FUNC_ADD,
                        ($urandom_range(0, 5) == 0) ? rand_word()
                                                    : 32'(int'($urandom_range(0, 800)) - 300)));
                nrand++;
            end

            // Long receiver hold-off while the sender keeps offering
            if (nrand > 300 && !stall_done) begin
                stall_done = 1;
                long_stall = 1;
                repeat (400) @(posedge i_clk);
                long_stall = 0;
            end
            // Sender pause until drained
            if (nrand > 600 && !drain_done) begin
                drain_done = 1;
                wait (pending_cmds.size() == 0);
                hold_sender = 1;
                while (expected_frames.size() != 0 || in_ch.valid) @(posedge i_clk);
                hold_sender = 0;
            end
        end

        while (pending_cmds.size() != 0 || in_ch.valid) @(posedge i_clk);
        while (expected_frames.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && expected_frames.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
